// ===== src/ssqe_pkg.sv =====
// Shared constants, codes and controller/datapath types for the sorted set query engine.
// No dependencies.
package ssqe_pkg;

   localparam int SET_DEPTH = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(SET_DEPTH);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int RANK_W    = 10;
   localparam int MODE_W    = 4;
   localparam int STAT_W    = 2;

   // Query and load operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD     = 4'd0,
      MODE_GET      = 4'd1,
      MODE_GE       = 4'd2,
      MODE_GT       = 4'd3,
      MODE_LE       = 4'd4,
      MODE_LT       = 4'd5,
      MODE_CNT_LT   = 4'd6,
      MODE_CNT_LE   = 4'd7,
      MODE_CONTAINS = 4'd8,
      MODE_RANGE    = 4'd9,
      MODE_NEIGHBOR = 4'd10
   } mode_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_RANK      = 2'd1,
      ST_REVERSED  = 2'd2,
      ST_NOT_BUILT = 2'd3
   } status_type;

   // Search pass selector
   typedef enum logic [1:0] {
      PASS_LB    = 2'd0,
      PASS_UB    = 2'd1,
      PASS_UPPER = 2'd2
   } pass_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic     accept;
      logic     dispatch;
      logic     ld_rd;
      logic     ld_cmp;
      logic     dd_init;
      logic     dd_rd;
      logic     dd_cmp;
      logic     bs_init;
      logic     bs_rd;
      logic     bs_cmp;
      logic     fetch_a;
      logic     fetch_b;
      logic     fetch_end;
      logic     finish;
      pass_type pass;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_load;
      logic full;
      logic last;
      logic mode_bad;
      logic built;
      logic is_range;
      logic idx_zero;
      logic rd_gt_key;
      logic idx_at_end;
      logic lo_lt_hi;
      logic out_free;
   } stat_type;

endpackage

// ===== src/ssqe_if.sv =====
// Channel interfaces for the sorted set query engine: request, response, register write.
// Depends on ssqe_pkg.
interface ssqe_req_if import ssqe_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [MODE_W-1:0]           mode;
   logic signed [KEY_WIDTH-1:0] key;
   logic signed [KEY_WIDTH-1:0] upper_key;
   logic [RANK_W-1:0]           rank;
   logic                        last;
   modport source (output valid, mode, key, upper_key, rank, last, input ready);
   modport sink (input valid, mode, key, upper_key, rank, last, output ready);
endinterface

interface ssqe_rsp_if import ssqe_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [KEY_WIDTH-1:0] value;
   logic [CNT_W-1:0]            count;
   logic                        found;
   logic [CNT_W-1:0]            set_size;
   logic [STAT_W-1:0]           status;
   modport source (output valid, value, count, found, set_size, status, input ready);
   modport sink (input valid, value, count, found, set_size, status, output ready);
endinterface

interface ssqe_csr_if import ssqe_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [KEY_WIDTH-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== src/ssqe_ctrl.sv =====
// Sequencer for load, sort-by-insertion, dedup and binary search queries.
// Depends on ssqe_pkg.
module ssqe_ctrl import ssqe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_DISPATCH  = 13'b0000000000010,
      S_LD_RD     = 13'b0000000000100,
      S_LD_CMP    = 13'b0000000001000,
      S_DD_INIT   = 13'b0000000010000,
      S_DD_RD     = 13'b0000000100000,
      S_DD_CMP    = 13'b0000001000000,
      S_BS_INIT   = 13'b0000010000000,
      S_BS_RD     = 13'b0000100000000,
      S_BS_CMP    = 13'b0001000000000,
      S_FETCH_A   = 13'b0010000000000,
      S_FETCH_B   = 13'b0100000000000,
      S_FETCH_END = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;
   logic      resp_ff, resp_in;

   assign req_ready = (state_ff == S_IDLE) && !resp_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      resp_in  = resp_ff;
      cmd      = '0;
      cmd.pass = pass_ff;
      if (resp_ff) begin
         // hold the finished beat until the output register frees up
         if (stat.out_free) begin
            cmd.finish = 1'b1;
            resp_in    = 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               cmd.dispatch = 1'b1;
               pass_in      = PASS_LB;
               if (stat.is_load) begin
                  if (!stat.full) begin
                     state_in = S_LD_RD;
                  end else if (stat.last) begin
                     state_in = S_DD_INIT;
                  end else begin
                     state_in = S_IDLE;
                     resp_in  = 1'b1;
                  end
               end else if (stat.mode_bad || !stat.built) begin
                  state_in = S_IDLE;
                  resp_in  = 1'b1;
               end else begin
                  state_in = S_BS_INIT;
               end
            end
            S_LD_RD: begin
               cmd.ld_rd = 1'b1;
               if (!stat.idx_zero) begin
                  state_in = S_LD_CMP;
               end else if (stat.last) begin
                  state_in = S_DD_INIT;
               end else begin
                  state_in = S_IDLE;
                  resp_in  = 1'b1;
               end
            end
            S_LD_CMP: begin
               cmd.ld_cmp = 1'b1;
               if (stat.rd_gt_key) begin
                  state_in = S_LD_RD;
               end else if (stat.last) begin
                  state_in = S_DD_INIT;
               end else begin
                  state_in = S_IDLE;
                  resp_in  = 1'b1;
               end
            end
            S_DD_INIT: begin
               cmd.dd_init = 1'b1;
               state_in    = S_DD_RD;
            end
            S_DD_RD: begin
               cmd.dd_rd = 1'b1;
               if (stat.idx_at_end) begin
                  state_in = S_IDLE;
                  resp_in  = 1'b1;
               end else begin
                  state_in = S_DD_CMP;
               end
            end
            S_DD_CMP: begin
               cmd.dd_cmp = 1'b1;
               state_in   = S_DD_RD;
            end
            S_BS_INIT: begin
               cmd.bs_init = 1'b1;
               state_in    = S_BS_RD;
            end
            S_BS_RD: begin
               cmd.bs_rd = 1'b1;
               if (stat.lo_lt_hi) begin
                  state_in = S_BS_CMP;
               end else begin
                  // advance to the next bound or to the element fetch
                  priority if (pass_ff == PASS_LB) begin
                     pass_in  = PASS_UB;
                     state_in = S_BS_INIT;
                  end else if (pass_ff == PASS_UB && stat.is_range) begin
                     pass_in  = PASS_UPPER;
                     state_in = S_BS_INIT;
                  end else begin
                     state_in = S_FETCH_A;
                  end
               end
            end
            S_BS_CMP: begin
               cmd.bs_cmp = 1'b1;
               state_in   = S_BS_RD;
            end
            S_FETCH_A: begin
               cmd.fetch_a = 1'b1;
               state_in    = S_FETCH_B;
            end
            S_FETCH_B: begin
               cmd.fetch_b = 1'b1;
               state_in    = S_FETCH_END;
            end
            S_FETCH_END: begin
               cmd.fetch_end = 1'b1;
               state_in      = S_IDLE;
               resp_in       = 1'b1;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= PASS_LB;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         resp_ff  <= resp_in;
      end
   end

endmodule

// ===== src/ssqe_datapath.sv =====
// Element store, counters, search registers and result register of the query engine.
// Depends on ssqe_pkg.
module ssqe_datapath import ssqe_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output stat_type                    stat,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   input  logic signed [KEY_WIDTH-1:0] req_upper_key,
   input  logic [RANK_W-1:0]           req_rank,
   input  logic                        req_last,
   input  logic                        csr_valid,
   input  logic signed [KEY_WIDTH-1:0] csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [KEY_WIDTH-1:0] rsp_value,
   output logic [CNT_W-1:0]            rsp_count,
   output logic                        rsp_found,
   output logic [CNT_W-1:0]            rsp_set_size,
   output logic [STAT_W-1:0]           rsp_status
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   // Sorted element store
   logic signed [KEY_WIDTH-1:0] mem [SET_DEPTH];
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   logic signed [KEY_WIDTH-1:0] wr_data;
   logic signed [KEY_WIDTH-1:0] rd_ff;

   // Captured request and control registers
   mode_type                    mode_ff, mode_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in, upper_ff, upper_in;
   logic [RANK_W-1:0]           rank_ff, rank_in;
   logic                        last_ff, last_in;
   logic [CNT_W-1:0]            loaded_ff, loaded_in, distinct_ff, distinct_in;
   logic                        built_ff, built_in;
   logic signed [KEY_WIDTH-1:0] missing_ff, missing_in;
   status_type                  status_ff, status_in;
   logic [CNT_W-1:0]            idx_ff, idx_in, wrp_ff, wrp_in;
   logic signed [KEY_WIDTH-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]            lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CNT_W-1:0]            lb_ff, lb_in, ub_ff, ub_in, ubr_ff, ubr_in;
   logic signed [KEY_WIDTH-1:0] a_ff, a_in, b_ff, b_in;

   // Result register
   logic                        ov_ff, ov_in;
   logic signed [KEY_WIDTH-1:0] oval_ff, oval_in;
   logic [CNT_W-1:0]            ocnt_ff, ocnt_in, osize_ff, osize_in;
   logic                        ofound_ff, ofound_in;
   status_type                  ost_ff, ost_in;

   logic [CNT_W:0]              mid_sum;
   logic [CNT_W-1:0]            mid;
   logic signed [KEY_WIDTH-1:0] target;
   logic                        go_right;
   logic [CNT_W-1:0]            addr_a, addr_b;
   logic                        is_load, mode_bad;
   logic signed [KEY_WIDTH:0]   diff_g, diff_l;

   assign is_load  = (mode_ff == MODE_LOAD);
   assign mode_bad = (mode_ff > MODE_NEIGHBOR);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CNT_W:1];
   assign target   = (cmd.pass == PASS_UPPER) ? upper_ff : key_ff;
   assign go_right = (cmd.pass == PASS_UB) ? (rd_ff <= target) : (rd_ff < target);
   assign addr_b   = ub_ff - ONE_CNT;
   assign diff_g   = {a_ff[KEY_WIDTH-1], a_ff} - {key_ff[KEY_WIDTH-1], key_ff};
   assign diff_l   = {key_ff[KEY_WIDTH-1], key_ff} - {b_ff[KEY_WIDTH-1], b_ff};

   // Pick the element that the answer needs
   always_comb begin
      unique case (mode_ff)
         MODE_GET: addr_a = CNT_W'(rank_ff);
         MODE_GT:  addr_a = ub_ff;
         MODE_LE:  addr_a = ub_ff - ONE_CNT;
         MODE_LT:  addr_a = lb_ff - ONE_CNT;
         default:  addr_a = lb_ff;
      endcase
   end

   assign stat.is_load    = is_load;
   assign stat.full       = (loaded_ff == DEPTH_CNT);
   assign stat.last       = last_ff;
   assign stat.mode_bad   = mode_bad;
   assign stat.built      = built_ff;
   assign stat.is_range   = (mode_ff == MODE_RANGE);
   assign stat.idx_zero   = (idx_ff == '0);
   assign stat.rd_gt_key  = (rd_ff > key_ff);
   assign stat.idx_at_end = (idx_ff == loaded_ff);
   assign stat.lo_lt_hi   = (lo_ff < hi_ff);
   assign stat.out_free   = !ov_ff || rsp_ready;

   // Memory port selection and register updates
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = idx_ff[ADDR_W-1:0];
      wr_data     = key_ff;
      rd_addr     = idx_ff[ADDR_W-1:0];
      mode_in     = mode_ff;
      key_in      = key_ff;
      upper_in    = upper_ff;
      rank_in     = rank_ff;
      last_in     = last_ff;
      loaded_in   = loaded_ff;
      distinct_in = distinct_ff;
      built_in    = built_ff;
      missing_in  = csr_valid ? csr_data : missing_ff;
      status_in   = status_ff;
      idx_in      = idx_ff;
      wrp_in      = wrp_ff;
      prev_in     = prev_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      lb_in       = lb_ff;
      ub_in       = ub_ff;
      ubr_in      = ubr_ff;
      a_in        = a_ff;
      b_in        = b_ff;

      if (cmd.accept) begin
         mode_in  = mode_type'(req_mode);
         key_in   = req_key;
         upper_in = req_upper_key;
         rank_in  = req_rank;
         last_in  = req_last;
         // drop the old set when a new load begins
         if (req_mode == MODE_LOAD && built_ff) begin
            loaded_in   = '0;
            distinct_in = '0;
            built_in    = 1'b0;
         end
      end
      if (cmd.dispatch) begin
         idx_in = loaded_ff;
         if (is_load ? (loaded_ff == DEPTH_CNT) : (!mode_bad && !built_ff)) begin
            status_in = ST_NOT_BUILT;
         end else begin
            status_in = ST_OK;
         end
      end
      // insertion: shift larger elements up one place
      if (cmd.ld_rd) begin
         rd_addr = ADDR_W'(idx_ff - ONE_CNT);
         if (idx_ff == '0) begin
            wr_en     = 1'b1;
            loaded_in = loaded_ff + ONE_CNT;
         end
      end
      if (cmd.ld_cmp) begin
         wr_en = 1'b1;
         if (rd_ff > key_ff) begin
            wr_data = rd_ff;
            idx_in  = idx_ff - ONE_CNT;
         end else begin
            loaded_in = loaded_ff + ONE_CNT;
         end
      end
      // dedup: compact distinct values to the front
      if (cmd.dd_init) begin
         idx_in = '0;
         wrp_in = '0;
      end
      if (cmd.dd_rd && idx_ff == loaded_ff) begin
         distinct_in = wrp_ff;
         built_in    = 1'b1;
      end
      if (cmd.dd_cmp) begin
         idx_in = idx_ff + ONE_CNT;
         if (wrp_ff == '0 || rd_ff != prev_ff) begin
            wr_en   = 1'b1;
            wr_addr = wrp_ff[ADDR_W-1:0];
            wr_data = rd_ff;
            prev_in = rd_ff;
            wrp_in  = wrp_ff + ONE_CNT;
         end
      end
      // binary search for one bound
      if (cmd.bs_init) begin
         lo_in = '0;
         hi_in = distinct_ff;
      end
      if (cmd.bs_rd) begin
         rd_addr = mid[ADDR_W-1:0];
         mid_in  = mid;
         if (lo_ff >= hi_ff) begin
            unique case (cmd.pass)
               PASS_LB: lb_in  = lo_ff;
               PASS_UB: ub_in  = lo_ff;
               default: ubr_in = lo_ff;
            endcase
         end
      end
      if (cmd.bs_cmp) begin
         if (go_right) begin
            lo_in = mid_ff + ONE_CNT;
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.fetch_a) begin
         rd_addr = addr_a[ADDR_W-1:0];
      end
      if (cmd.fetch_b) begin
         a_in    = rd_ff;
         rd_addr = addr_b[ADDR_W-1:0];
      end
      if (cmd.fetch_end) begin
         b_in = rd_ff;
      end
   end

   // Form the result beat
   always_comb begin
      oval_in   = missing_ff;
      ocnt_in   = '0;
      ofound_in = 1'b0;
      ost_in    = status_ff;
      osize_in  = distinct_ff;
      if (is_load) begin
         oval_in = '0;
      end else if (mode_bad) begin
         ost_in = ST_OK;
      end else if (status_ff == ST_OK) begin
         unique case (mode_ff)
            MODE_GET: begin
               if (CNT_W'(rank_ff) < distinct_ff) begin
                  oval_in = a_ff;
               end else begin
                  ost_in = ST_RANK;
               end
            end
            MODE_GE: if (lb_ff < distinct_ff) oval_in = a_ff;
            MODE_GT: if (ub_ff < distinct_ff) oval_in = a_ff;
            MODE_LE: if (ub_ff != '0) oval_in = a_ff;
            MODE_LT: if (lb_ff != '0) oval_in = a_ff;
            MODE_CNT_LT: begin
               oval_in = '0;
               ocnt_in = lb_ff;
            end
            MODE_CNT_LE: begin
               oval_in = '0;
               ocnt_in = ub_ff;
            end
            MODE_CONTAINS: begin
               oval_in   = '0;
               ofound_in = (lb_ff < distinct_ff) && (a_ff == key_ff);
               ocnt_in   = CNT_W'(ofound_in);
            end
            MODE_RANGE: begin
               oval_in = '0;
               if (key_ff > upper_ff) begin
                  ost_in = ST_REVERSED;
               end else begin
                  ocnt_in = ubr_ff - lb_ff;
               end
            end
            default: begin
               // nearest neighbor, lower element wins a tie
               priority if (lb_ff < distinct_ff && ub_ff != '0) begin
                  oval_in = (diff_g < diff_l) ? a_ff : b_ff;
               end else if (lb_ff < distinct_ff) begin
                  oval_in = a_ff;
               end else if (ub_ff != '0) begin
                  oval_in = b_ff;
               end else begin
                  oval_in = missing_ff;
               end
            end
         endcase
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (cmd.finish) begin
         ov_in = 1'b1;
      end else if (rsp_ready) begin
         ov_in = 1'b0;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         distinct_ff <= '0;
         built_ff    <= 1'b0;
         missing_ff  <= '1;
         ov_ff       <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         distinct_ff <= distinct_in;
         built_ff    <= built_in;
         missing_ff  <= missing_in;
         ov_ff       <= ov_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      upper_ff  <= upper_in;
      rank_ff   <= rank_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      wrp_ff    <= wrp_in;
      prev_ff   <= prev_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      lb_ff     <= lb_in;
      ub_ff     <= ub_in;
      ubr_ff    <= ubr_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      if (cmd.finish) begin
         oval_ff   <= oval_in;
         ocnt_ff   <= ocnt_in;
         ofound_ff <= ofound_in;
         osize_ff  <= osize_in;
         ost_ff    <= ost_in;
      end
   end

   assign rsp_valid    = ov_ff;
   assign rsp_value    = oval_ff;
   assign rsp_count    = ocnt_ff;
   assign rsp_found    = ofound_ff;
   assign rsp_set_size = osize_ff;
   assign rsp_status   = ost_ff;

endmodule

// ===== src/sorted_set_query_engine_top.sv =====
// Sorted set query engine: load keys, build a sorted distinct set, answer rank/bound queries.
// Depends on ssqe_pkg, ssqe_if, ssqe_ctrl and ssqe_datapath.
//
// Usage: req_chan carries one beat per operation (mode, key, upper_key, rank, last);
// rsp_chan returns exactly one beat per request; csr_chan writes the missing value
// register (always ready, reset value -1); the user must write it only while the block
// is idle, as the block itself does not enforce this. Loads insert the key into sorted
// position in a 1024-entry store with one write port and one registered read port,
// moving each larger element up one place by a memory read, then a compare and write.
// The beat marked last then compacts duplicates. A query runs two binary searches
// (three for a range count); each search has a setup step, a memory read and a compare
// per probe, and a closing step that stores the bound. A query before the set is built
// skips the searches and returns the not-built status.
// One item is worked at a time. The result sits in an output register; a new request
// can be accepted while it waits, and that item holds its own result until the
// receiver takes the earlier beat. Reset empties the set and clears both channels.
module sorted_set_query_engine_top import ssqe_pkg::*; (
   input logic       clock,
   input logic       reset,
   ssqe_req_if.sink  req_chan,
   ssqe_rsp_if.source rsp_chan,
   ssqe_csr_if.sink  csr_chan
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_chan.ready = 1'b1;

   ssqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssqe_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_mode      (req_chan.mode),
      .req_key       (req_chan.key),
      .req_upper_key (req_chan.upper_key),
      .req_rank      (req_chan.rank),
      .req_last      (req_chan.last),
      .csr_valid     (csr_chan.valid),
      .csr_data      (csr_chan.data),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_value     (rsp_chan.value),
      .rsp_count     (rsp_chan.count),
      .rsp_found     (rsp_chan.found),
      .rsp_set_size  (rsp_chan.set_size),
      .rsp_status    (rsp_chan.status)
   );

endmodule

// ===== src/ssqe_checker.sv =====
// Port-level checks for the sorted set query engine, bound to the top level.
// Depends on ssqe_pkg and sorted_set_query_engine_top.
module ssqe_checker import ssqe_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CNT_W-1:0]  rsp_count,
   input logic              rsp_found,
   input logic [STAT_W-1:0] rsp_status
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // one item at a time: no back-to-back request beats
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in consecutive cycles");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_count == CNT_W'(1))
      else $error("found without count of one");

   a_reversed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_REVERSED |-> rsp_count == '0 && !rsp_found)
      else $error("reversed range with nonzero count");

   a_not_built: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_BUILT |-> rsp_count == '0 && !rsp_found)
      else $error("not-built status with an answer");

endmodule

bind sorted_set_query_engine_top ssqe_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_count  (rsp_chan.count),
   .rsp_found  (rsp_chan.found),
   .rsp_status (rsp_chan.status)
);

// ===== dv/sorted_set_query_engine_top_tb.sv =====
// Self-checking testbench for the sorted set query engine: loads key sets, runs every query
// mode against a local predictor, checks each response beat. Needs ssqe_pkg, ssqe_if, top.
module sorted_set_query_engine_top_tb;
   import ssqe_pkg::*;

   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] value;
      logic [CNT_W-1:0]            count;
      logic                        found;
      logic [CNT_W-1:0]            set_size;
      logic [STAT_W-1:0]           status;
   } answer_type;

   // mode codes outside the defined set
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd13;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssqe_req_if req_chan ();
   ssqe_rsp_if rsp_chan ();
   ssqe_csr_if csr_chan ();

   sorted_set_query_engine_top DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [KEY_WIDTH-1:0] set_keys [SET_DEPTH];
   int unsigned                 held_cnt;
   int unsigned                 uniq_cnt;
   bit                          is_built;
   logic signed [KEY_WIDTH-1:0] miss_val;

   answer_type answer_q[$];
   int         mismatches;
   int         stall_pct;
   bit         burst_mode;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode = '0;
      req_chan.key = '0;
      req_chan.upper_key = '0;
      req_chan.rank = '0;
      req_chan.last = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      held_cnt = 0;
      uniq_cnt = 0;
      is_built = 0;
      miss_val = -1;
      mismatches = 0;
      stall_pct = 30;
      burst_mode = 1;
   end

   // sort held keys ascending and drop duplicates
   function automatic void build_keys();
      logic signed [KEY_WIDTH-1:0] t;
      int w;
      for (int i = 1; i < held_cnt; i++) begin
         t = set_keys[i];
         for (int j = i - 1; j >= -1; j--) begin
            if (j < 0 || set_keys[j] <= t) begin
               set_keys[j+1] = t;
               break;
            end
            set_keys[j+1] = set_keys[j];
         end
      end
      w = 0;
      for (int i = 0; i < held_cnt; i++)
         if (w == 0 || set_keys[i] != set_keys[w-1]) begin
            set_keys[w] = set_keys[i];
            w++;
         end
      uniq_cnt = w;
      is_built = 1;
   endfunction

   // elements < k (strict) or <= k
   function automatic int unsigned rank_of(logic signed [KEY_WIDTH-1:0] k, bit strict);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = uniq_cnt;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (strict ? (set_keys[mid] < k) : (set_keys[mid] <= k)) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic answer_type predict_answer(logic [MODE_W-1:0] mode,
         logic signed [KEY_WIDTH-1:0] key, logic signed [KEY_WIDTH-1:0] upk,
         logic [RANK_W-1:0] rank, logic last);
      answer_type a;
      int unsigned lb, ub, n;
      longint g, l, k;
      a.value = miss_val;
      a.count = '0;
      a.found = 1'b0;
      a.status = ST_OK;
      n = uniq_cnt;
      if (mode == MODE_LOAD) begin
         a.value = '0;
         if (is_built) begin
            is_built = 0;
            held_cnt = 0;
            uniq_cnt = 0;
         end
         if (held_cnt < SET_DEPTH) begin
            set_keys[held_cnt] = key;
            held_cnt++;
         end else a.status = ST_NOT_BUILT;
         if (last) build_keys();
      end else if (mode > MODE_NEIGHBOR) begin
         // unused mode: no effect
      end else if (!is_built) begin
         a.status = ST_NOT_BUILT;
      end else begin
         lb = rank_of(key, 1);
         ub = rank_of(key, 0);
         unique case (mode)
            MODE_GET: if (rank < n) a.value = set_keys[rank]; else a.status = ST_RANK;
            MODE_GE: if (lb < n) a.value = set_keys[lb];
            MODE_GT: if (ub < n) a.value = set_keys[ub];
            MODE_LE: if (ub > 0) a.value = set_keys[ub-1];
            MODE_LT: if (lb > 0) a.value = set_keys[lb-1];
            MODE_CNT_LT: begin a.value = '0; a.count = CNT_W'(lb); end
            MODE_CNT_LE: begin a.value = '0; a.count = CNT_W'(ub); end
            MODE_CONTAINS: begin
               a.value = '0;
               a.found = (lb < n && set_keys[lb] == key);
               a.count = CNT_W'(a.found);
            end
            MODE_RANGE: begin
               a.value = '0;
               if (key > upk) a.status = ST_REVERSED;
               else a.count = CNT_W'(rank_of(upk, 1) - lb);
            end
            default: begin
               if (lb < n && ub > 0) begin
                  g = set_keys[lb];
                  l = set_keys[ub-1];
                  k = key;
                  a.value = (g - k < k - l) ? set_keys[lb] : set_keys[ub-1];
               end else if (lb < n) a.value = set_keys[lb];
               else if (ub > 0) a.value = set_keys[ub-1];
            end
         endcase
      end
      a.set_size = CNT_W'(uniq_cnt);
      return a;
   endfunction

   // send one request beat; predict at acceptance
   task automatic send_item(logic [MODE_W-1:0] mode, logic signed [KEY_WIDTH-1:0] key,
         logic signed [KEY_WIDTH-1:0] upk = '0, logic [RANK_W-1:0] rank = '0,
         logic last = 1'b0);
      req_chan.mode <= mode;
      req_chan.key <= key;
      req_chan.upper_key <= upk;
      req_chan.rank <= rank;
      req_chan.last <= last;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      answer_q.push_back(predict_answer(mode, key, upk, rank, last));
      @(negedge clock);
      // gap between bursts, or after every beat outside burst mode
      if (!burst_mode || $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   endtask

   task automatic end_stream();
      req_chan.valid <= 1'b0;
      while (answer_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_missing(logic signed [KEY_WIDTH-1:0] v);
      end_stream();
      csr_chan.data <= v;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      miss_val = v;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // receiver stall pattern
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);

   // check each response beat against the oldest answer
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.value, rsp_chan.count, rsp_chan.found, rsp_chan.set_size,
                rsp_chan.status};
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
         end else begin
            want = answer_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp value %0d count %0d found %0d size %0d st %0d",
                            " / got %0d %0d %0d %0d %0d"},
                     want.value, want.count, want.found, want.set_size, want.status,
                     got.value, got.count, got.found, got.set_size, got.status);
            end
         end
      end
   end

   function automatic logic signed [KEY_WIDTH-1:0] rand_key(int spread);
      unique case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7fffffff - $urandom_range(0, 2);
         2: return -32'sh7fffffff - 1 + $urandom_range(0, 2);
         default: return $signed($urandom_range(0, 2 * spread)) - spread;
      endcase
   endfunction

   task automatic test_directed();
      logic [MODE_W-1:0] m;
      // queries before any build
      send_item(MODE_GE, 5);
      send_item(MODE_GET, 0);
      send_item(MODE_SPARE_LO, 1);
      // small set with extremes and duplicates
      send_item(MODE_LOAD, 32'sh7fffffff);
      send_item(MODE_LOAD, -32'sh7fffffff - 1);
      send_item(MODE_LOAD, 10);
      send_item(MODE_LOAD, 10);
      send_item(MODE_LOAD, -1, 0, 0, 1);
      for (int i = 1; i <= 10; i++) begin
         m = MODE_W'(i);
         send_item(m, 10, 32'sh7fffffff, 4);
      end
      send_item(MODE_GET, 0, 0, 1023);
      send_item(MODE_RANGE, 5, 4);
      send_item(MODE_NEIGHBOR, 4);
      send_item(MODE_NEIGHBOR, 32'sh7ffffff0);
      send_item(MODE_SPARE_HI, 3);
   endtask

   task automatic test_missing_extremes();
      write_missing(32'sh7fffffff);
      send_item(MODE_GT, 32'sh7fffffff);
      write_missing(-32'sh7fffffff - 1);
      send_item(MODE_LT, -32'sh7fffffff - 1);
      write_missing(10);
      send_item(MODE_GE, 11);
   endtask

   task automatic test_full_store();
      // overflow a full store, then build
      burst_mode = 1;
      for (int i = 0; i < SET_DEPTH + 2; i++)
         send_item(MODE_LOAD, $urandom, 0, 0, i == SET_DEPTH + 1);
      send_item(MODE_CNT_LE, 32'sh7fffffff);
      send_item(MODE_GET, 0, 0, 1023);
   endtask

   task automatic test_random(int total);
      int sent, sz, spread;
      logic [MODE_W-1:0] m;
      logic [RANK_W-1:0] r;
      logic              lst;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 3) == 0) begin
            stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(10, 80);
            burst_mode = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 15) == 0) write_missing($urandom);
         sz = $urandom_range(1, 12);
         spread = $urandom_range(0, 1) ? 20 : 1000000;
         for (int i = 0; i < sz; i++) begin
            lst = (i == sz - 1) || ($urandom_range(0, 9) == 0);
            send_item(MODE_LOAD, rand_key(spread), 0, 0, lst);
            sent++;
         end
         repeat ($urandom_range(5, 25)) begin
            m = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom)
                                              : MODE_W'($urandom_range(1, 10));
            if (m == MODE_LOAD) m = MODE_GE;
            r = ($urandom_range(0, 15) == 0) ? RANK_W'($urandom)
                                              : RANK_W'($urandom_range(0, 14));
            lst = 1'($urandom);
            send_item(m, rand_key(spread), rand_key(spread), r, lst);
            sent++;
         end
      end
   endtask

   initial begin
      #1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_missing_extremes();
      test_full_store();
      test_random(750);
      write_missing(-1);
      end_stream();
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #100000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== sorted_set_query_engine_top.f =====
src/ssqe_pkg.sv
src/ssqe_if.sv
src/ssqe_ctrl.sv
src/ssqe_datapath.sv
src/sorted_set_query_engine_top.sv
src/ssqe_checker.sv
dv/sorted_set_query_engine_top_tb.sv
